[rtl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN_LEN_DEF = 16;
    localparam int PAT_BYTES           = 16;
    localparam int LEN_W               = 5;
    localparam int ADDR_W              = 64;
    localparam int DATA_W              = 64;
    localparam int PADDR_W             = 6;

    typedef enum logic [2:0] {
        REG_PAT_LO = 3'd0,
        REG_PAT_HI = 3'd1,
        REG_WILD   = 3'd2,
        REG_LEN    = 3'd3,
        REG_BASE   = 3'd4
    } reg_idx_t;

    // per-cell view of the pattern, derived from the config registers
    typedef struct packed {
        logic       active;
        logic       wild;
        logic [7:0] pat;
    } cell_cfg_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } result_t;

    function automatic logic [7:0] pattern_byte(
        input logic [63:0] lo,
        input logic [63:0] hi,
        input logic [3:0]  pos
    );
        logic [63:0] word;
        word = pos[3] ? hi : lo;
        return word[{pos[2:0], 3'b000} +: 8];
    endfunction

endpackage

[rtl/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window slot: holds a byte of a fixed age and compares the byte that
// moves in against its pattern position.
// ----------------------------------------------------------------------------
module wbps_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  wbps_pkg::cell_cfg_t cfg,
    input  logic               shift_en,
    input  logic               clear,
    input  logic [7:0]         byte_in,
    input  logic               valid_in,
    output logic [7:0]         byte_out,
    output logic               valid_out,
    output logic               hit
);
    import wbps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb
    begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift_en)
        begin
            byte_next  = byte_in;
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // compare on the window as it stands after this byte shifts in
    assign hit       = !cfg.active || (valid_in && (cfg.wild || byte_in == cfg.pat));
    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

[rtl/wbps_out_buf.sv]
// ----------------------------------------------------------------------------
// wbps_out_buf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module wbps_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wbps_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output wbps_pkg::result_t out_data
);
    import wbps_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/wildcard_byte_pattern_scan.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Sliding-window search of a byte stream for a pattern with wildcards.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back, while in_stall is low. The window
// is a row of MAX_PATTERN_LEN cells that shift by one on every accepted byte
// until the region reports a match; all cells compare in the same cycle,
// and a result is registered. A two-entry result buffer keeps input flowing
// while a result waits; in_stall rises only when both entries hold. No
// clearing pass after reset. Config registers are 64 bits at byte address
// 8*i; write them only while the scanner is idle.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN_LEN = wbps_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0] paddr,
    input  logic [wbps_pkg::DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::DATA_W-1:0]  prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [wbps_pkg::ADDR_W-1:0]  match_address
);
    import wbps_pkg::*;

    logic [63:0]      pat_lo_reg;
    logic [63:0]      pat_hi_reg;
    logic [15:0]      wild_reg;
    logic [LEN_W-1:0] len_reg;
    logic [63:0]      base_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] offset_next;
    logic              reported_reg;
    logic              reported_next;

    logic              accept;
    logic              shift_en;
    logic              match;
    logic              push;
    result_t           push_data;
    result_t           out_data;
    logic              buf_full;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  len_m1;

    logic [7:0]        chain_byte  [MAX_PATTERN_LEN+1];
    logic              chain_valid [MAX_PATTERN_LEN+1];
    logic [MAX_PATTERN_LEN-1:0] hit;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            wild_reg   <= '0;
            len_reg    <= LEN_W'(1);
            base_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PAT_LO: pat_lo_reg <= pwdata;
                REG_PAT_HI: pat_hi_reg <= pwdata;
                REG_WILD:   wild_reg   <= pwdata[15:0];
                REG_LEN:    len_reg    <= pwdata[LEN_W-1:0];
                REG_BASE:   base_reg   <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PAT_LO: prdata = pat_lo_reg;
            REG_PAT_HI: prdata = pat_hi_reg;
            REG_WILD:   prdata = DATA_W'(wild_reg);
            REG_LEN:    prdata = DATA_W'(len_reg);
            REG_BASE:   prdata = base_reg;
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_PATTERN_LEN))
        begin
            len_eff = LEN_W'(MAX_PATTERN_LEN);
        end
        else
        begin
            len_eff = len_reg;
        end
    end
    assign len_m1 = len_eff - LEN_W'(1);

    // cell chain
    assign accept   = in_valid && !in_stall;
    assign shift_en = accept && !reported_reg;

    assign chain_byte[0]  = data_byte;
    assign chain_valid[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
    begin : g_cell
        logic [LEN_W-1:0] pos;
        cell_cfg_t        ccfg;

        assign pos         = len_m1 - LEN_W'(k);
        assign ccfg.active = LEN_W'(k) < len_eff;
        assign ccfg.wild   = wild_reg[pos[3:0]];
        assign ccfg.pat    = pattern_byte(pat_lo_reg, pat_hi_reg, pos[3:0]);

        wbps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (ccfg),
            .shift_en  (shift_en),
            .clear     (accept && last_byte),
            .byte_in   (chain_byte[k]),
            .valid_in  (chain_valid[k]),
            .byte_out  (chain_byte[k+1]),
            .valid_out (chain_valid[k+1]),
            .hit       (hit[k])
        );
    end

    assign match = &hit;

    // scan control
    always_comb
    begin
        offset_next   = offset_reg;
        reported_next = reported_reg;
        push          = 1'b0;
        push_data     = '0;
        if (shift_en)
        begin
            offset_next = offset_reg + ADDR_W'(1);
            if (match)
            begin
                push           = 1'b1;
                push_data.found = 1'b1;
                push_data.addr = base_reg + offset_reg - ADDR_W'(len_m1);
                reported_next  = 1'b1;
            end
            else if (last_byte)
            begin
                push = 1'b1;
            end
        end
        if (accept && last_byte)
        begin
            offset_next   = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            offset_reg   <= offset_next;
            reported_reg <= reported_next;
        end
    end

    wbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign in_stall      = buf_full;
    assign found         = out_data.found;
    assign match_address = out_data.addr;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for wildcard_byte_pattern_scan
// Drives regions of bytes through the scanner and checks every transaction
// on the result port against a built-in prediction of each region's first
// match of the configured pattern, or its miss. The run covers directed cases
// at the reset configuration, several register settings (the extremes among
// them), random idling on both sides, a long result stall and a no-idle stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int WIN_DEPTH   = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } scan_item_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [7:0]          data_byte = '0;
    logic                last_byte = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                found;
    logic [ADDR_W-1:0]   match_address;

    logic                steady    = 1'b0;
    logic                hold_req  = 1'b0;
    logic                hold_ack  = 1'b0;
    int                  hold_left = 0;
    int                  cycle_count = 0;
    int                  mismatches  = 0;

    scan_item_t          pending_bytes[$];
    result_t             expected_matches[$];

    // configuration shadow
    logic [127:0]        cfg_pat  = '0;
    logic [15:0]         cfg_wild = '0;
    logic [4:0]          cfg_len  = 5'd1;
    logic [63:0]         cfg_base = '0;

    // scan state shadow
    logic [7:0]          win [WIN_DEPTH];
    int                  win_fill = 0;
    logic [63:0]         region_offset = '0;
    logic                match_done = 1'b0;

    wildcard_byte_pattern_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int scan_len();
        if (cfg_len == 5'd0)
            return 1;
        if (cfg_len > 5'd16)
            return WIN_DEPTH;
        return int'(cfg_len);
    endfunction

    function automatic logic [7:0] pat_at(input int pos);
        return cfg_pat[8*pos +: 8];
    endfunction

    function automatic void restart_region();
        foreach (win[k])
            win[k] = 8'h00;
        win_fill      = 0;
        region_offset = '0;
        match_done    = 1'b0;
    endfunction

    function automatic void predict_match(input logic [7:0] b, input logic last);
        int          plen;
        logic [63:0] here;
        logic        hit;
        if (!match_done)
        begin
            plen = scan_len();
            here = region_offset;
            for (int k = WIN_DEPTH - 1; k > 0; k--)
                win[k] = win[k-1];
            win[0] = b;
            if (win_fill < WIN_DEPTH)
                win_fill++;
            region_offset = region_offset + 64'd1;
            hit = (win_fill >= plen);
            for (int i = 0; i < plen; i++)
                if (!cfg_wild[i] && win[plen-1-i] != pat_at(i))
                    hit = 1'b0;
            if (hit)
            begin
                expected_matches.push_back('{1'b1, cfg_base + here - 64'(plen - 1)});
                match_done = 1'b1;
            end
            else if (last)
                expected_matches.push_back('{1'b0, 64'd0});
        end
        if (last)
            restart_region();
    endfunction

    // byte feeder
    always @(posedge clk or negedge rst_n)
    begin : feeder
        scan_item_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_match(data_byte, last_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 7))
                begin
                    nxt = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= nxt.value;
                    last_byte <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_ack  <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    $error("unexpected result transaction: found=%0b match_address=%h",
                           found, match_address);
                    mismatches++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, found);
                        mismatches++;
                    end
                    if (match_address !== want.addr)
                    begin
                        $error("match_address: expected %h, got %h",
                               want.addr, match_address);
                        mismatches++;
                    end
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  <= hold_req;
                hold_left <= 80;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            out_stall <= (hold_req != hold_ack) || (hold_left > 1) ||
                         (!steady && $urandom_range(0, 99) < 7);
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_matches.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PAT_LO: cfg_pat[63:0]   = v;
            REG_PAT_HI: cfg_pat[127:64] = v;
            REG_WILD:   cfg_wild        = v[15:0];
            REG_LEN:    cfg_len         = v[4:0];
            REG_BASE:   cfg_base        = v;
            default: ;
        endcase
    endtask

    function automatic logic [7:0] filler_byte();
        int pos;
        pos = $urandom_range(0, 15);
        if ($urandom_range(0, 1) != 0)
            return pat_at(pos);
        return 8'($urandom);
    endfunction

    function automatic void push_item(input logic [7:0] v, input logic last);
        scan_item_t it;
        it.value = v;
        it.last  = last;
        pending_bytes.push_back(it);
    endfunction

    // one region: mostly a pattern copy with random surroundings,
    // some near misses, overlapping runs and plain noise
    task automatic add_region(output int count);
        logic [7:0] seq[$];
        int         plen, kind, pos, base_idx;
        plen = scan_len();
        kind = $urandom_range(0, 9);
        if (kind == 8)
            repeat ($urandom_range(1, 20)) seq.push_back(filler_byte());
        else
        begin
            if (kind != 9)
                repeat ($urandom_range(0, 10)) seq.push_back(filler_byte());
            else
                repeat ($urandom_range(1, 4)) seq.push_back(pat_at(0));
            base_idx = seq.size();
            for (int i = 0; i < plen; i++)
                seq.push_back(cfg_wild[i] ? 8'($urandom) : pat_at(i));
            if (kind == 6 || kind == 7)
            begin
                pos = $urandom_range(0, plen - 1);
                if (!cfg_wild[pos])
                    seq[base_idx + pos] = seq[base_idx + pos] ^ 8'($urandom_range(1, 255));
            end
            repeat ($urandom_range(0, 6)) seq.push_back(filler_byte());
        end
        foreach (seq[k])
            push_item(seq[k], k == seq.size() - 1);
        count = seq.size();
    endtask

    task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [15:0] mask, input logic [4:0] len,
                             input logic [63:0] base, input int n_items);
        int sent;
        int c;
        wait_idle();
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_WILD, {48'd0, mask});
        write_reg(REG_LEN, {59'd0, len});
        write_reg(REG_BASE, base);
        sent = 0;
        while (sent < n_items)
        begin
            add_region(c);
            sent += c;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        restart_region();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: single byte 0x00, no wildcard
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h55, 1'b0);
        push_item(8'hAA, 1'b1);
        push_item(8'h00, 1'b1);
        push_item(8'h7F, 1'b0);
        push_item(8'h80, 1'b1);

        // 12 ? 34 at the top of the address space: short region, overlap,
        // address wrap and bytes after the match
        wait_idle();
        write_reg(REG_PAT_LO, 64'h0000_0000_0034_0012);
        write_reg(REG_PAT_HI, 64'h0);
        write_reg(REG_WILD, 64'h2);
        write_reg(REG_LEN, 64'd3);
        write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(8'h12, 1'b1);
        push_item(8'h12, 1'b0);
        push_item(8'h12, 1'b0);
        push_item(8'h12, 1'b0);
        push_item(8'h34, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'h34, 1'b0);
        push_item(8'h12, 1'b1);

        run_phase({64{1'b1}}, {64{1'b1}}, 16'h0000, 5'd16, 64'h0, 120);
        run_phase(rand64(), rand64(), 16'hFFFF, 5'd16, rand64(), 80);
        run_phase(rand64(), rand64(), 16'h0000, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 100);
        run_phase(rand64(), rand64(), 16'(rand64() & rand64()), 5'd31, rand64(), 100);
        run_phase(64'h0, 64'h0, 16'h8001, 5'd17, rand64(), 100);

        for (int p = 0; p < 9; p++)
        begin
            if (p == 4)
            begin
                @(posedge clk);
                steady <= 1'b1;
            end
            run_phase(rand64(), rand64(), 16'($urandom & $urandom & $urandom),
                      5'($urandom_range(1, 6)), rand64(), 120);
            if (p == 4)
            begin
                wait_idle();
                steady <= 1'b0;
            end
        end

        // every byte ends a region and matches: results pile up behind a long stall
        run_phase(rand64(), rand64(), 16'h0001, 5'd1, rand64(), 0);
        @(posedge clk);
        hold_req <= ~hold_req;
        repeat (40) push_item(8'($urandom), 1'b1);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[wildcard_byte_pattern_scan.f]
rtl/wbps_pkg.sv
rtl/wbps_cell.sv
rtl/wbps_out_buf.sv
rtl/wildcard_byte_pattern_scan.sv
bench/testbench.sv
